// File: hdl/tlba_pkg.sv
// ----------------------------------------------------------------------------
// tlba_pkg
// Types, constants and helpers shared by the two-level bitmap id allocator.
// ----------------------------------------------------------------------------
package tlba_pkg;

  localparam int DESC_W      = 12;
  localparam int GROUP_COUNT = 64;
  localparam int GROUP_BITS  = 64;
  localparam int GROUP_IDX_W = 6;
  localparam int BIT_IDX_W   = 6;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLAIM   = 2'd2
  } opcode_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [DESC_W-1:0]   descriptor;
  } req_t;

  typedef struct packed {
    logic [DESC_W-1:0]   granted;
    logic                success;
  } rsp_t;

  // request as held between the group read and the update
  typedef struct packed {
    opcode_t                opcode;
    logic [DESC_W-1:0]      descriptor;
    logic [GROUP_IDX_W-1:0] grp;
    logic                   found;
  } item_t;

  // write-back of one group word and its full mark
  typedef struct packed {
    logic                   wr_en;
    logic [GROUP_IDX_W-1:0] grp;
    logic [GROUP_BITS-1:0]  word;
    logic                   full;
  } wr_t;

  // {found, index} of the lowest set bit
  function automatic logic [BIT_IDX_W:0] lowest_set(input logic [GROUP_BITS-1:0] v);
    logic                 hit;
    logic [BIT_IDX_W-1:0] idx;
    hit = |v;
    idx = '0;
    for (int i = GROUP_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_IDX_W'(i);
      end
    end
    return {hit, idx};
  endfunction

endpackage

// File: hdl/two_level_bitmap_id_allocator_core.sv
// ----------------------------------------------------------------------------
// two_level_bitmap_id_allocator_core
// Hands out, releases and claims descriptor numbers from a two-level bitmap.
// ----------------------------------------------------------------------------
// A request is taken into the held stage (s_item) as its group word is read
// from the 64-entry group memory (the group for an allocate is the lowest one
// whose full mark is clear); when the response side lets the stage move on,
// the change is applied, the word written back and the response registered. One
// request is taken every cycle while responses are taken; back-to-back requests
// to the same group see each other's updates through a one-word bypass. The
// group memory reads as all free after reset without any clearing pass.
module two_level_bitmap_id_allocator_core #(
  parameter int DESCRIPTOR_COUNT = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  tlba_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output tlba_pkg::rsp_t  rsp
);
  import tlba_pkg::*;

  localparam int GROUPS = (DESCRIPTOR_COUNT + GROUP_BITS - 1) / GROUP_BITS;
  localparam logic [GROUP_COUNT-1:0] EXIST_MASK =
    (GROUP_COUNT'(1) << GROUPS) - GROUP_COUNT'(1);

  logic [GROUP_BITS-1:0]  mem [GROUP_COUNT];
  logic [GROUP_COUNT-1:0] vld;
  logic [GROUP_COUNT-1:0] marks;
  logic [GROUP_COUNT-1:0] marks_next;

  logic                   s_valid;
  item_t                  s_item;
  logic [GROUP_BITS-1:0]  rd_word;
  logic                   rd_vld;
  logic                   byp_en;
  logic [GROUP_IDX_W-1:0] byp_grp;
  logic [GROUP_BITS-1:0]  byp_word;

  logic                   advance;
  logic                   accept;
  logic                   wr_fire;
  logic [GROUP_BITS-1:0]  s_word;
  logic [BIT_IDX_W:0]     alloc_pick;
  item_t                  in_item;
  wr_t                    upd_wr;
  rsp_t                   upd_rsp;

  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = advance;
  assign accept    = req_valid && advance;
  assign wr_fire   = s_valid && advance && upd_wr.wr_en;

  always_comb begin
    marks_next = marks;
    if (wr_fire) begin
      marks_next[upd_wr.grp] = upd_wr.full;
    end
  end

  // lowest existing group that is not full, seen after the update in flight
  assign alloc_pick = lowest_set(~marks_next & EXIST_MASK);

  always_comb begin
    in_item.opcode     = req.opcode;
    in_item.descriptor = req.descriptor;
    in_item.found      = alloc_pick[BIT_IDX_W];
    in_item.grp        = (req.opcode == OP_ALLOC) ? alloc_pick[BIT_IDX_W-1:0]
                                                  : req.descriptor[DESC_W-1:BIT_IDX_W];
  end

  // the read misses a write on the same edge, so take the bypassed word
  assign s_word = (byp_en && byp_grp == s_item.grp) ? byp_word
                : (rd_vld ? rd_word : '0);

  tlba_group_update #(
    .DESCRIPTOR_COUNT (DESCRIPTOR_COUNT)
  ) u_update (
    .item (s_item),
    .word (s_word),
    .wr   (upd_wr),
    .rsp  (upd_rsp)
  );

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[upd_wr.grp] <= upd_wr.word;
    end
    if (accept) begin
      rd_word <= mem[in_item.grp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      marks     <= '0;
      vld       <= '0;
      s_valid   <= 1'b0;
      rsp_valid <= 1'b0;
      byp_en    <= 1'b0;
    end else begin
      marks <= marks_next;
      if (wr_fire) begin
        vld[upd_wr.grp] <= 1'b1;
      end
      if (advance) begin
        s_valid   <= accept;
        rsp_valid <= s_valid;
        byp_en    <= wr_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_item <= in_item;
      rd_vld <= vld[in_item.grp];
    end
    if (advance) begin
      rsp      <= upd_rsp;
      byp_grp  <= upd_wr.grp;
      byp_word <= upd_wr.word;
    end
  end

  // a held request keeps its contents until it moves on
  assert property (@(posedge clk) disable iff (rst)
    s_valid && !advance |=> s_valid && $stable(s_item))
    else $error("held request changed while stalled");

  // a write-back marks the group full exactly when its word is full
  assert property (@(posedge clk) disable iff (rst)
    wr_fire |=> marks[$past(upd_wr.grp)] == $past(upd_wr.full))
    else $error("full mark does not follow written group word");

  // groups beyond the descriptor count are never marked full
  assert property (@(posedge clk) disable iff (rst)
    wr_fire |=> (marks & ~EXIST_MASK) == '0)
    else $error("full mark set on a group that does not exist");

  // a successful allocate answers inside the group it read
  assert property (@(posedge clk) disable iff (rst)
    s_valid && advance && s_item.opcode == OP_ALLOC && upd_rsp.success
    |=> rsp.granted[DESC_W-1:BIT_IDX_W] == $past(s_item.grp))
    else $error("allocate answered outside its group");

endmodule

// File: hdl/tlba_group_update.sv
// ----------------------------------------------------------------------------
// tlba_group_update
// Applies one request to its group word: picks the lowest free bit, sets or
// clears a given bit, and works out the new full mark and the response.
// ----------------------------------------------------------------------------
module tlba_group_update #(
  parameter int DESCRIPTOR_COUNT = 4096
) (
  input  tlba_pkg::item_t                      item,
  input  logic [tlba_pkg::GROUP_BITS-1:0]      word,
  output tlba_pkg::wr_t                        wr,
  output tlba_pkg::rsp_t                       rsp
);
  import tlba_pkg::*;

  localparam int FULL_GROUPS = DESCRIPTOR_COUNT / GROUP_BITS;
  localparam int REM_BITS    = DESCRIPTOR_COUNT % GROUP_BITS;
  localparam logic [GROUP_BITS-1:0] PART_MASK =
    (GROUP_BITS'(1) << REM_BITS) - GROUP_BITS'(1);

  logic [GROUP_BITS-1:0] vmask;
  logic [GROUP_BITS-1:0] bit_oh;
  logic [GROUP_BITS-1:0] free_bits;
  logic [GROUP_BITS-1:0] new_word;
  logic [BIT_IDX_W:0]    free_pick;
  logic                  in_range;
  logic                  wr_en;
  logic                  ok;
  logic [DESC_W-1:0]     granted;

  // only bits below the descriptor count exist in a partial last group
  assign vmask = ({1'b0, item.grp} < 7'(FULL_GROUPS)) ? '1 : PART_MASK;

  assign bit_oh    = GROUP_BITS'(1) << item.descriptor[BIT_IDX_W-1:0];
  assign in_range  = {1'b0, item.descriptor} < 13'(DESCRIPTOR_COUNT);
  assign free_bits = ~word & vmask;
  assign free_pick = lowest_set(free_bits);

  always_comb begin
    new_word = word;
    wr_en    = 1'b0;
    ok       = 1'b0;
    granted  = item.descriptor;
    case (item.opcode)
      OP_ALLOC: begin
        granted = '0;
        if (item.found && free_pick[BIT_IDX_W]) begin
          new_word = word | (GROUP_BITS'(1) << free_pick[BIT_IDX_W-1:0]);
          wr_en    = 1'b1;
          ok       = 1'b1;
          granted  = {item.grp, free_pick[BIT_IDX_W-1:0]};
        end
      end
      OP_RELEASE: begin
        if (in_range) begin
          new_word = word & ~bit_oh;
          wr_en    = 1'b1;
          ok       = 1'b1;
        end
      end
      OP_CLAIM: begin
        if (in_range && !(|(word & bit_oh))) begin
          new_word = word | bit_oh;
          wr_en    = 1'b1;
          ok       = 1'b1;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign wr.wr_en = wr_en;
  assign wr.grp   = item.grp;
  assign wr.word  = new_word;
  assign wr.full  = (new_word & vmask) == vmask;

  assign rsp.granted = granted;
  assign rsp.success = ok;

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-level bitmap id allocator. A short table of
// requests is followed by a run of allocates that fills the lowest groups,
// then by random release, claim, allocate and unused-opcode traffic.
// Every response is compared with its table entry or an in-bench bitmap
// predictor, and random idling and stalls are applied on both handshakes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tlba_pkg::*;

  localparam int DESC_COUNT = 4096;
  localparam int DESC_LIMIT = (DESC_COUNT < 64) ? 64 : ((DESC_COUNT > 4096) ? 4096 : DESC_COUNT);
  localparam int GROUPS_USED = (DESC_LIMIT + 63) / 64;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int FILL_REQUESTS   = 130;
  localparam int RANDOM_REQUESTS = 450;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int PRESSURE_AT     = 60;
  localparam int PRESSURE_CYCLES = 300;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  two_level_bitmap_id_allocator_core #(
    .DESCRIPTOR_COUNT(DESC_COUNT)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  // bitmap state mirrored by the predictor
  logic [GROUP_BITS-1:0] used_words [GROUP_COUNT];
  logic [GROUP_COUNT-1:0] full_marks;

  rsp_t awaited_rsp_q[$];

  int mismatches;
  int requests_sent;
  int responses_seen;
  int grants_made;
  int allocs_refused;
  int claims_refused;
  int releases_done;
  int req_calm;
  int rsp_calm;
  logic [DESC_W-1:0] last_desc;

  typedef struct packed {
    logic [1:0]        op;
    logic [DESC_W-1:0] desc;
    logic              typed;
    logic [DESC_W-1:0] exp_granted;
    logic              exp_ok;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 22;
  stim_row_t directed_rows [DIRECTED_ROWS];

  function automatic logic [GROUP_BITS-1:0] group_mask(input int g);
    int left;
    left = DESC_LIMIT - g * 64;
    if (g >= GROUPS_USED) return '0;
    if (left >= 64) return '1;
    return (64'd1 << left) - 64'd1;
  endfunction

  function automatic void mark_if_full(input int g);
    logic [GROUP_BITS-1:0] m;
    m = group_mask(g);
    if ((used_words[g] & m) == m) full_marks[g] = 1'b1;
  endfunction

  function automatic rsp_t predict_grant(input req_t r);
    rsp_t o;
    int g;
    int b;
    int lo;
    logic [GROUP_BITS-1:0] free_bits;
    o.granted = r.descriptor;
    o.success = 1'b0;
    g = int'(r.descriptor[DESC_W-1:BIT_IDX_W]);
    b = int'(r.descriptor[BIT_IDX_W-1:0]);
    case (r.opcode)
      OP_ALLOC: begin
        o.granted = '0;
        for (int gi = 0; gi < GROUPS_USED && !o.success; gi++) begin
          if (!full_marks[gi]) begin
            free_bits = ~used_words[gi] & group_mask(gi);
            if (free_bits == '0) begin
              // stale clear mark on a group that is in fact full
              full_marks[gi] = 1'b1;
            end else begin
              lo = 0;
              for (int bi = GROUP_BITS - 1; bi >= 0; bi--) begin
                if (free_bits[bi]) lo = bi;
              end
              used_words[gi][lo] = 1'b1;
              mark_if_full(gi);
              o.granted = DESC_W'(gi * 64 + lo);
              o.success = 1'b1;
            end
          end
        end
        if (o.success) grants_made++;
        else allocs_refused++;
      end
      OP_RELEASE: begin
        if (int'(r.descriptor) < DESC_LIMIT) begin
          used_words[g][b] = 1'b0;
          full_marks[g] = 1'b0;
          o.success = 1'b1;
          releases_done++;
        end
      end
      OP_CLAIM: begin
        if (int'(r.descriptor) < DESC_LIMIT && !used_words[g][b]) begin
          used_words[g][b] = 1'b1;
          mark_if_full(g);
          o.success = 1'b1;
        end else begin
          claims_refused++;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // zero-gap runs are mixed in so that back-to-back traffic happens too
  function automatic int pick_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [DESC_W-1:0] pick_descriptor();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return DESC_W'($urandom_range(0, 4095));
    if (sel < 70) return DESC_W'($urandom_range(0, 191));
    if (sel < 85) return last_desc;
    return {DESC_W'($urandom_range(0, 63)) << BIT_IDX_W} |
           (($urandom_range(0, 1) == 1) ? DESC_W'(63) : DESC_W'(0));
  endfunction

  task automatic send_request(input req_t r, input logic typed, input rsp_t typed_rsp);
    int gap;
    rsp_t predicted;
    gap = pick_gap(req_calm);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    predicted = predict_grant(r);
    awaited_rsp_q.push_back(typed ? typed_rsp : predicted);
    requests_sent++;
    last_desc = r.descriptor;
    @(negedge clk);
  endtask

  initial begin : stimulus
    req_t r;
    rsp_t t;
    int sel;
    logic [1:0] code;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    mismatches = 0;
    requests_sent = 0;
    grants_made = 0;
    allocs_refused = 0;
    claims_refused = 0;
    releases_done = 0;
    req_calm = 0;
    last_desc = '0;
    for (int g = 0; g < GROUP_COUNT; g++) used_words[g] = '0;
    full_marks = '0;

    directed_rows = '{
      '{OP_ALLOC,   12'h000, 1'b1, 12'h000, 1'b1},
      '{OP_ALLOC,   12'hFFF, 1'b1, 12'h001, 1'b1},
      '{OP_CLAIM,   12'hFFF, 1'b1, 12'hFFF, 1'b1},
      '{OP_CLAIM,   12'hFFF, 1'b1, 12'hFFF, 1'b0},
      '{OP_CLAIM,   12'h002, 1'b1, 12'h002, 1'b1},
      '{OP_ALLOC,   12'h000, 1'b1, 12'h003, 1'b1},
      '{OP_RELEASE, 12'h000, 1'b1, 12'h000, 1'b1},
      '{OP_ALLOC,   12'h555, 1'b1, 12'h000, 1'b1},
      '{OP_RELEASE, 12'h064, 1'b1, 12'h064, 1'b1},
      '{OP_UNUSED,  12'hABC, 1'b1, 12'hABC, 1'b0},
      '{OP_UNUSED,  12'h543, 1'b1, 12'h543, 1'b0},
      '{OP_CLAIM,   12'h03F, 1'b0, 12'h000, 1'b0},
      '{OP_CLAIM,   12'h040, 1'b0, 12'h000, 1'b0},
      '{OP_RELEASE, 12'hFFF, 1'b1, 12'hFFF, 1'b1},
      '{OP_CLAIM,   12'h555, 1'b0, 12'h000, 1'b0},
      '{OP_CLAIM,   12'hAAA, 1'b0, 12'h000, 1'b0},
      '{OP_RELEASE, 12'h555, 1'b0, 12'h000, 1'b0},
      '{OP_ALLOC,   12'h000, 1'b0, 12'h000, 1'b0},
      '{OP_ALLOC,   12'hAAA, 1'b0, 12'h000, 1'b0},
      '{OP_RELEASE, 12'h002, 1'b0, 12'h000, 1'b0},
      '{OP_ALLOC,   12'h000, 1'b0, 12'h000, 1'b0},
      '{OP_RELEASE, 12'hFFF, 1'b1, 12'hFFF, 1'b1}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      r.opcode = opcode_t'(directed_rows[i].op);
      r.descriptor = directed_rows[i].desc;
      t.granted = directed_rows[i].exp_granted;
      t.success = directed_rows[i].exp_ok;
      send_request(r, directed_rows[i].typed, t);
    end

    // allocate past the lowest groups so that their full marks get set
    t = '0;
    for (int i = 0; i < FILL_REQUESTS; i++) begin
      r.opcode = OP_ALLOC;
      r.descriptor = DESC_W'($urandom_range(0, 4095));
      send_request(r, 1'b0, t);
    end

    // first half leans towards release, second half towards allocate
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      sel = $urandom_range(0, 99);
      if (i < RANDOM_REQUESTS / 2) begin
        code = (sel < 50) ? OP_RELEASE : (sel < 75) ? OP_ALLOC :
               (sel < 95) ? OP_CLAIM : OP_UNUSED;
      end else begin
        code = (sel < 45) ? OP_ALLOC : (sel < 70) ? OP_RELEASE :
               (sel < 95) ? OP_CLAIM : OP_UNUSED;
      end
      r.opcode = opcode_t'(code);
      r.descriptor = pick_descriptor();
      send_request(r, 1'b0, t);
    end
    req_valid <= 1'b0;

    while (awaited_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests with full groups and long back-pressure, %0d grants",
             requests_sent, grants_made);
    $display("%0d refused allocates, %0d refused claims, %0d releases",
             allocs_refused, claims_refused, releases_done);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : response_side
    int gap;
    rsp_t want;
    logic held;
    rsp_ready = 1'b0;
    responses_seen = 0;
    rsp_calm = 0;
    held = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (responses_seen == PRESSURE_AT && !held) begin
        // long back-pressure so the request side backs up and stalls
        held = 1'b1;
        rsp_ready <= 1'b0;
        for (int c = 0; c < PRESSURE_CYCLES; c++) @(negedge clk);
      end
      gap = pick_gap(rsp_calm);
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      if (awaited_rsp_q.size() == 0) begin
        mismatches++;
        $display("%0t: response with none outstanding: granted %0d success %0b",
                 $time, rsp.granted, rsp.success);
      end else begin
        want = awaited_rsp_q.pop_front();
        if (rsp.granted !== want.granted) begin
          mismatches++;
          $display("%0t: granted expected %0d actual %0d",
                   $time, want.granted, rsp.granted);
        end
        if (rsp.success !== want.success) begin
          mismatches++;
          $display("%0t: success expected %0b actual %0b",
                   $time, want.success, rsp.success);
        end
      end
      responses_seen++;
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no request or response moved for %0d cycles", $time, STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

endmodule
